// ----- hw/rtl/clcms_pkg.sv -----
// Package for the complex lag correlation moving sum unit.
// Holds the sample, product and sum widths and the window length.
// No dependencies.
package clcms_pkg;

    localparam int WINDOW      = 16;
    localparam int SAMPLE_BITS = 16;
    // a*c + b*d of two SAMPLE_BITS operands needs one bit beyond the raw product
    localparam int PROD_BITS   = 2 * SAMPLE_BITS + 1;
    // WINDOW products summed need clog2(WINDOW) more bits
    localparam int SUM_BITS    = PROD_BITS + $clog2(WINDOW);
    // run counter saturates at WINDOW, so it must hold WINDOW itself
    localparam int RUN_BITS    = $clog2(WINDOW + 1);

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [PROD_BITS-1:0]   prod_t;
    typedef logic signed [SUM_BITS-1:0]    sum_t;
    typedef logic [RUN_BITS-1:0]           run_t;

endpackage

// ----- hw/rtl/complex_lag_correlation_moving_sum_unit.sv -----
// Complex lag correlation with a windowed moving sum, one transaction per cycle
// unless out_ready stalls the output. Pipeline: input register, product register,
// then the sum register that drives the outputs.
// Throughput: one transaction per clock when not stalled, set by the sum update
// of the 37-bit running sums; the product stage is a single 16x16 multiply level.
// Reset (rst_n low, asynchronous): pipeline empty, delay line, sums and run count zero.
module complex_lag_correlation_moving_sum_unit
    import clcms_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,

    input  logic           in_valid,
    output logic           in_ready,
    input  logic           sample_valid,
    input  sample_t        cur_re,
    input  sample_t        cur_im,
    input  sample_t        lag_re,
    input  sample_t        lag_im,

    output logic           out_valid,
    input  logic           out_ready,
    output sum_t           sum_re,
    output sum_t           sum_im,
    output logic           window_full
);

    // stage 1: input register
    logic    s1_v_reg;
    logic    s1_sv_reg;
    sample_t s1_a_reg, s1_b_reg, s1_c_reg, s1_d_reg;

    // stage 2: product register
    logic    s2_v_reg;
    logic    s2_sv_reg;
    prod_t   s2_p_re_reg, s2_p_im_reg;

    // stage 3: running state, drives the outputs
    logic    out_v_reg;
    sum_t    running_re_reg, running_im_reg;
    sum_t    running_re_next, running_im_next;
    run_t    run_length_reg, run_length_next;
    prod_t   line_re_reg [WINDOW];
    prod_t   line_im_reg [WINDOW];

    logic    out_free, s2_adv, s2_free, s1_adv, s1_free, in_acc;

    logic signed [2*SAMPLE_BITS-1:0] mul_ac, mul_bd, mul_bc, mul_ad;
    prod_t   p_re_next, p_im_next;

    // handshake chain: a stage moves when the one after it is empty or moving
    assign out_free = !out_v_reg || out_ready;
    assign s2_adv   = s2_v_reg && out_free;
    assign s2_free  = !s2_v_reg || s2_adv;
    assign s1_adv   = s1_v_reg && s2_free;
    assign s1_free  = !s1_v_reg || s1_adv;
    assign in_ready = s1_free;
    assign in_acc   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
        end
        else if (s1_free)
        begin
            s1_v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_sv_reg <= sample_valid;
            s1_a_reg  <= cur_re;
            s1_b_reg  <= cur_im;
            s1_c_reg  <= lag_re;
            s1_d_reg  <= lag_im;
        end
    end

    // r(k) * conj(r(k-N)); zero the product for an invalid sample
    always_comb
    begin
        mul_ac = s1_a_reg * s1_c_reg;
        mul_bd = s1_b_reg * s1_d_reg;
        mul_bc = s1_b_reg * s1_c_reg;
        mul_ad = s1_a_reg * s1_d_reg;
        if (s1_sv_reg)
        begin
            p_re_next = PROD_BITS'(mul_ac) + PROD_BITS'(mul_bd);
            p_im_next = PROD_BITS'(mul_bc) - PROD_BITS'(mul_ad);
        end
        else
        begin
            p_re_next = '0;
            p_im_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_v_reg <= 1'b0;
        end
        else if (s2_free)
        begin
            s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s2_sv_reg   <= s1_sv_reg;
            s2_p_re_reg <= p_re_next;
            s2_p_im_reg <= p_im_next;
        end
    end

    // add the new product, drop the oldest one leaving the window
    always_comb
    begin
        running_re_next = running_re_reg + SUM_BITS'(s2_p_re_reg)
                          - SUM_BITS'(line_re_reg[WINDOW-1]);
        running_im_next = running_im_reg + SUM_BITS'(s2_p_im_reg)
                          - SUM_BITS'(line_im_reg[WINDOW-1]);
        if (!s2_sv_reg)
        begin
            run_length_next = '0;
        end
        else if (run_length_reg < RUN_BITS'(WINDOW))
        begin
            run_length_next = run_length_reg + RUN_BITS'(1);
        end
        else
        begin
            run_length_next = run_length_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg      <= 1'b0;
            running_re_reg <= '0;
            running_im_reg <= '0;
            run_length_reg <= '0;
            for (int i = 0; i < WINDOW; i++)
            begin
                line_re_reg[i] <= '0;
                line_im_reg[i] <= '0;
            end
        end
        else
        begin
            if (out_free)
            begin
                out_v_reg <= s2_v_reg;
            end
            if (s2_adv)
            begin
                running_re_reg <= running_re_next;
                running_im_reg <= running_im_next;
                run_length_reg <= run_length_next;
                line_re_reg[0] <= s2_p_re_reg;
                line_im_reg[0] <= s2_p_im_reg;
                for (int i = 1; i < WINDOW; i++)
                begin
                    line_re_reg[i] <= line_re_reg[i-1];
                    line_im_reg[i] <= line_im_reg[i-1];
                end
            end
        end
    end

    assign out_valid   = out_v_reg;
    assign sum_re      = running_re_reg;
    assign sum_im      = running_im_reg;
    assign window_full = (run_length_reg == RUN_BITS'(WINDOW));

    // run counter never passes the window length
    a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
        run_length_reg <= RUN_BITS'(WINDOW))
        else $error("run length exceeds window");

    // an invalid sample clears the run
    a_run_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_adv && !s2_sv_reg) |=> (run_length_reg == '0))
        else $error("invalid sample did not clear run length");

    // a valid sample below saturation advances the run by one
    a_run_incr: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_adv && s2_sv_reg && (run_length_reg < RUN_BITS'(WINDOW)))
        |=> (run_length_reg == $past(run_length_reg) + RUN_BITS'(1)))
        else $error("run length did not advance");

    // sums hold while no product leaves stage 2
    a_sum_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !s2_adv |=> ($stable(running_re_reg) && $stable(running_im_reg)))
        else $error("running sum changed without a product");

    // an empty input register always takes a transaction
    a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_v_reg |-> in_ready)
        else $error("input stalled with empty input register");

endmodule
